FILE: rtl/core/fnvht_pkg.sv
// ----------------------------------------------------------------------------
// fnvht_pkg
// Shared types and constants of the FNV-1a bucketed hash table.
// ----------------------------------------------------------------------------
package fnvht_pkg;

    localparam int unsigned BUCKETS     = 256;
    localparam int unsigned WAYS        = 4;
    localparam int unsigned KEY_BYTES   = 8;
    localparam int unsigned VALUE_WIDTH = 32;

    localparam int unsigned BKT_W  = $clog2(BUCKETS);
    localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned FILL_W = $clog2(WAYS + 1);
    localparam int unsigned SLOT_W = BKT_W + WAY_W;
    localparam int unsigned CNT_W  = 11;
    localparam int unsigned BYTE_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;
    localparam logic [63:0] KEY_MASK  = (KEY_BYTES >= 8) ? '1 :
        ((64'd1 << (8 * KEY_BYTES)) - 64'd1);

    typedef enum logic [1:0] {
        OP_GET_INSERT = 2'd0,
        OP_STORE      = 2'd1,
        OP_HAS        = 2'd2,
        OP_DELETE     = 2'd3
    } op_t;

    typedef logic [VALUE_WIDTH-1:0] val_t;

    // Slot memory port request from the controller
    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [63:0]       wr_key;
        val_t              wr_val;
    } slot_req_t;

endpackage

FILE: rtl/core/fnvht_hash.sv
// ----------------------------------------------------------------------------
// fnvht_hash
// Iterative 64-bit FNV-1a: one key byte per step, with the multiply split
// into 32x32 partial products: the low one first, then the cross terms.
// ----------------------------------------------------------------------------
module fnvht_hash (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [63:0]                  key,
    output logic                         done,
    output logic [fnvht_pkg::BKT_W-1:0]  bucket
);

    logic [63:0] key_reg, key_next;
    logic [63:0] h_reg, h_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] lo_reg, lo_next;
    logic [fnvht_pkg::BYTE_W-1:0] idx_reg, idx_next;
    logic busy_reg, busy_next;
    logic phase_reg, phase_next;
    logic done_reg, done_next;
    logic [7:0] cur_byte;
    logic [63:0] hx;

    assign cur_byte = key_reg[8*idx_reg +: 8];
    assign hx       = h_reg ^ {56'd0, cur_byte};

    always_comb begin
        key_next   = key_reg;
        h_next     = h_reg;
        x_next     = x_reg;
        lo_next    = lo_reg;
        idx_next   = idx_reg;
        busy_next  = busy_reg;
        phase_next = phase_reg;
        done_next  = 1'b0;
        if (start) begin
            key_next   = key;
            h_next     = fnvht_pkg::FNV_BASIS;
            idx_next   = '0;
            busy_next  = 1'b1;
            phase_next = 1'b0;
        end else if (busy_reg) begin
            if (!phase_reg) begin
                // low 32 bits of x times low 32 bits of the prime: x_lo * p_lo
                x_next     = hx;
                lo_next    = hx[31:0] * fnvht_pkg::FNV_PRIME[31:0];
                phase_next = 1'b1;
            end else begin
                // add x_hi*p_lo and x_lo*p_hi into the upper half
                h_next = lo_reg + {(x_reg[63:32] * fnvht_pkg::FNV_PRIME[31:0]
                    + x_reg[31:0] * fnvht_pkg::FNV_PRIME[63:32]), 32'd0};
                phase_next = 1'b0;
                if (32'(idx_reg) == fnvht_pkg::KEY_BYTES - 1) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        h_reg   <= h_next;
        x_reg   <= x_next;
        lo_reg  <= lo_next;
        idx_reg <= idx_next;
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    assign done   = done_reg;
    assign bucket = h_reg[fnvht_pkg::BKT_W-1:0];

endmodule

FILE: rtl/core/fnvht_slot_mem.sv
// ----------------------------------------------------------------------------
// fnvht_slot_mem
// Slot store: key and value per slot, one write and one registered read.
// ----------------------------------------------------------------------------
module fnvht_slot_mem (
    input  logic                  aclk,
    input  fnvht_pkg::slot_req_t  req,
    output logic [63:0]           rd_key,
    output fnvht_pkg::val_t       rd_val
);

    localparam int unsigned DEPTH = fnvht_pkg::BUCKETS * (2 ** fnvht_pkg::WAY_W);

    logic [63:0]     key_mem [DEPTH];
    fnvht_pkg::val_t val_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            key_mem[req.wr_addr] <= req.wr_key;
            val_mem[req.wr_addr] <= req.wr_val;
        end
        if (req.rd_en) begin
            rd_key <= key_mem[req.rd_addr];
            rd_val <= val_mem[req.rd_addr];
        end
    end

endmodule

FILE: rtl/core/fnv1a_bucketed_hash_table.sv
// ----------------------------------------------------------------------------
// fnv1a_bucketed_hash_table
// Fixed-size hash table with FNV-1a bucketing and per-bucket slot lists.
// ----------------------------------------------------------------------------
// One request is handled at a time. The iterative FNV-1a unit is started,
// steps through the key one byte at a time and hands off the bucket. The
// bucket's fill count is then taken. The slots are read from the slot
// memory and compared one at a time. A delete moves each later slot down
// one entry, by a read and then a write per slot, and then closes. The
// result is held in an output register, and s_ready returns in the cycle
// after it has been taken. Bucket fill counts live in a small memory, read
// at the hash unit's bucket, with one valid bit per bucket so that no
// clearing pass is needed after reset.
module fnv1a_bucketed_hash_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [63:0] s_key,
    input  logic [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_value_out,
    output logic        m_found,
    output logic        m_status,
    output logic [10:0] m_entry_count
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_HASH  = 7'b0000010,
        ST_FILL  = 7'b0000100,
        ST_READ  = 7'b0001000,
        ST_CMP   = 7'b0010000,
        ST_SHIFT = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    localparam int unsigned BKT_W  = fnvht_pkg::BKT_W;
    localparam int unsigned WAY_W  = fnvht_pkg::WAY_W;
    localparam int unsigned FILL_W = fnvht_pkg::FILL_W;

    state_t state_reg, state_next;
    fnvht_pkg::op_t op_reg, op_next;
    logic [63:0] key_reg, key_next;
    fnvht_pkg::val_t val_reg, val_next;
    logic [BKT_W-1:0] bkt_reg, bkt_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] j_reg, j_next;
    logic [WAY_W-1:0] pos_reg, pos_next;
    logic rd_pend_reg, rd_pend_next;
    logic [10:0] cnt_reg, cnt_next;
    logic [31:0] vout_reg, vout_next;
    logic found_reg, found_next;
    logic status_reg, status_next;
    logic mval_reg, mval_next;

    logic hash_start, hash_done;
    logic [BKT_W-1:0] hash_bkt;
    fnvht_pkg::slot_req_t req;
    logic [63:0] rd_key;
    fnvht_pkg::val_t rd_val;

    // fill counts: memory plus one valid bit per bucket
    logic [FILL_W-1:0] fill_mem [fnvht_pkg::BUCKETS];
    logic [fnvht_pkg::BUCKETS-1:0] fvalid_reg;
    logic [FILL_W-1:0] fill_rd_reg;
    logic fill_vld_reg;
    logic fill_we;
    logic [FILL_W-1:0] fill_wd;

    fnvht_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key     (key_reg),
        .done    (hash_done),
        .bucket  (hash_bkt)
    );

    fnvht_slot_mem u_mem (
        .aclk   (aclk),
        .req    (req),
        .rd_key (rd_key),
        .rd_val (rd_val)
    );

    always_ff @(posedge aclk) begin
        if (fill_we) fill_mem[bkt_reg] <= fill_wd;
        fill_rd_reg  <= fill_mem[hash_bkt];
        fill_vld_reg <= fvalid_reg[hash_bkt];
        if (!aresetn) begin
            fvalid_reg <= '0;
        end else if (fill_we) begin
            fvalid_reg[bkt_reg] <= 1'b1;
        end
    end

    assign s_ready    = (state_reg == ST_IDLE) && !mval_reg;
    assign hash_start = (state_reg == ST_HASH) && !rd_pend_reg;

    always_comb begin
        logic [63:0] kin;
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        val_next     = val_reg;
        bkt_next     = bkt_reg;
        fill_next    = fill_reg;
        j_next       = j_reg;
        pos_next     = pos_reg;
        rd_pend_next = rd_pend_reg;
        cnt_next     = cnt_reg;
        vout_next    = vout_reg;
        found_next   = found_reg;
        status_next  = status_reg;
        mval_next    = mval_reg;
        fill_we      = 1'b0;
        fill_wd      = fill_reg;
        req          = '0;
        kin          = s_key & fnvht_pkg::KEY_MASK;

        if (mval_reg && m_ready) mval_next = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    op_next      = fnvht_pkg::op_t'(s_opcode);
                    key_next     = kin;
                    val_next     = fnvht_pkg::val_t'(s_value);
                    rd_pend_next = 1'b0;
                    state_next   = ST_HASH;
                end
            end
            ST_HASH: begin
                // first cycle issues start; then wait for done
                rd_pend_next = 1'b1;
                if (hash_done) begin
                    bkt_next   = hash_bkt;
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                fill_next  = fill_vld_reg ? fill_rd_reg : '0;
                j_next     = '0;
                found_next = 1'b0;
                state_next = ST_READ;
            end
            ST_READ: begin
                if (j_reg < fill_reg) begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = {bkt_reg, j_reg[WAY_W-1:0]};
                    state_next  = ST_CMP;
                end else begin
                    // miss
                    vout_next   = '0;
                    status_next = 1'b0;
                    state_next  = ST_DONE;
                    if (op_reg == fnvht_pkg::OP_GET_INSERT ||
                        op_reg == fnvht_pkg::OP_STORE) begin
                        if (32'(fill_reg) < fnvht_pkg::WAYS) begin
                            req.wr_en   = 1'b1;
                            req.wr_addr = {bkt_reg, fill_reg[WAY_W-1:0]};
                            req.wr_key  = key_reg;
                            req.wr_val  = (op_reg == fnvht_pkg::OP_STORE) ?
                                val_reg : '0;
                            vout_next   = 32'(req.wr_val);
                            fill_we     = 1'b1;
                            fill_wd     = fill_reg + 1'b1;
                            cnt_next    = cnt_reg + 11'd1;
                        end else begin
                            status_next = 1'b1;
                        end
                    end
                end
            end
            ST_CMP: begin
                if (rd_key == key_reg) begin
                    found_next  = 1'b1;
                    status_next = 1'b0;
                    pos_next    = j_reg[WAY_W-1:0];
                    state_next  = ST_DONE;
                    unique case (op_reg)
                        fnvht_pkg::OP_STORE: begin
                            req.wr_en   = 1'b1;
                            req.wr_addr = {bkt_reg, j_reg[WAY_W-1:0]};
                            req.wr_key  = key_reg;
                            req.wr_val  = val_reg;
                            vout_next   = 32'(val_reg);
                        end
                        fnvht_pkg::OP_DELETE: begin
                            vout_next  = '0;
                            j_next     = j_reg + 1'b1;
                            fill_we    = 1'b1;
                            fill_wd    = fill_reg - 1'b1;
                            cnt_next   = cnt_reg - 11'd1;
                            rd_pend_next = 1'b0;
                            state_next = ST_SHIFT;
                        end
                        default: vout_next = 32'(rd_val);
                    endcase
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_SHIFT: begin
                // read slot j, then write it to j-1
                if (!rd_pend_reg) begin
                    if (j_reg < fill_reg) begin
                        req.rd_en    = 1'b1;
                        req.rd_addr  = {bkt_reg, j_reg[WAY_W-1:0]};
                        rd_pend_next = 1'b1;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else begin
                    req.wr_en    = 1'b1;
                    req.wr_addr  = {bkt_reg, pos_reg};
                    req.wr_key   = rd_key;
                    req.wr_val   = rd_val;
                    pos_next     = pos_reg + 1'b1;
                    j_next       = j_reg + 1'b1;
                    rd_pend_next = 1'b0;
                end
            end
            ST_DONE: begin
                mval_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        val_reg     <= val_next;
        bkt_reg     <= bkt_next;
        fill_reg    <= fill_next;
        j_reg       <= j_next;
        pos_reg     <= pos_next;
        vout_reg    <= vout_next;
        found_reg   <= found_next;
        status_reg  <= status_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_pend_reg <= 1'b0;
            cnt_reg     <= '0;
            mval_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_pend_next;
            cnt_reg     <= cnt_next;
            mval_reg    <= mval_next;
        end
    end

    assign m_valid       = mval_reg;
    assign m_value_out   = vout_reg;
    assign m_found       = found_reg;
    assign m_status      = status_reg;
    assign m_entry_count = cnt_reg;

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("request accepted while busy");
    a_status_no_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_status && m_found))
        else $error("full status on a hit");
    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != $past(cnt_reg)) |-> $past(fill_we))
        else $error("entry count moved without a fill update");
    a_no_dual_access: assert property (@(posedge aclk) disable iff (!aresetn)
        !(req.rd_en && req.wr_en))
        else $error("slot memory read and write in one cycle");

endmodule
